FILE: hw/rtl/line_fit_outlier_reject_unit_defines.svh
// Assertion macros for the verification files of the line fit unit.
// No dependencies; include by bare file name.
`ifndef LINE_FIT_OUTLIER_REJECT_UNIT_DEFINES_SVH
`define LINE_FIT_OUTLIER_REJECT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LFOR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LFOR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/lfor_pkg.sv
// Shared constants, command/status types and codes for the line fit unit.
// No dependencies.
package lfor_pkg;

    localparam int MaxPoints = 4096;
    localparam int AddrW     = $clog2(MaxPoints);
    localparam int CntW      = $clog2(MaxPoints + 1);
    localparam int MaxPasses = 16;
    localparam int PassW     = $clog2(MaxPasses + 1);
    localparam int OffW      = 16;
    localparam int TimeW     = 24;
    localparam int LimW      = 16;
    localparam int OutW      = 32;
    localparam int AccW      = 88;   // fit products and differences
    localparam int DenW      = 57;   // denominator magnitude
    localparam int MulBW     = 54;   // multiplier operand consumed bit-serially
    localparam int MulSteps  = MulBW;
    localparam int MulCntW   = $clog2(MulSteps);
    localparam int DivSteps  = AccW;
    localparam int DivCntW   = $clog2(DivSteps);
    localparam int GradShift = 20;

    localparam logic [LimW-1:0] LimitReset = 16'd2304;

    typedef logic [2:0] t_mul_op;
    localparam t_mul_op OpDenA = 3'd0;  // den  = used * sxx
    localparam t_mul_op OpDenB = 3'd1;  // den -= sx * sx
    localparam t_mul_op OpNsA  = 3'd2;  // ns   = used * sxy
    localparam t_mul_op OpNsB  = 3'd3;  // ns  -= sx * sy
    localparam t_mul_op OpNiA  = 3'd4;  // ni   = sy * sxx
    localparam t_mul_op OpNiB  = 3'd5;  // ni  -= sx * sxy

    localparam logic DivGrad = 1'b0;
    localparam logic DivIcpt = 1'b1;

    typedef struct packed {
        logic    load;
        logic    fit_init;
        logic    acc_init;
        logic    rd;
        logic    acc;
        logic    idx_inc;
        logic    mul_start;
        t_mul_op mul_op;
        logic    set_degen;
        logic    div_start;
        logic    div_sel;
        logic    res_init;
        logic    res_mul;
        logic    res_cmp;
        logic    emit;
    } t_ctl_cmd;

    typedef struct packed {
        logic idx_end;
        logic mul_done;
        logic div_done;
        logic fit_bad;
        logic pass_max;
        logic any_rej;
        logic out_free;
    } t_ctl_stat;

endpackage

FILE: hw/rtl/lfor_ctrl.sv
// Sequencer of the line fit unit: load, accumulate, solve, reject, emit.
// Depends on lfor_pkg.
module lfor_ctrl
    import lfor_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_last,
    output logic      o_in_ready,
    output t_ctl_cmd  o_cmd,
    input  t_ctl_stat i_stat
);

    localparam logic [3:0] S_LOAD     = 4'd0;
    localparam logic [3:0] S_ACC_INIT = 4'd1;
    localparam logic [3:0] S_ACC_RD   = 4'd2;
    localparam logic [3:0] S_ACC_ADD  = 4'd3;
    localparam logic [3:0] S_MUL_GO   = 4'd4;
    localparam logic [3:0] S_MUL_WAIT = 4'd5;
    localparam logic [3:0] S_CHECK    = 4'd6;
    localparam logic [3:0] S_DIV_G    = 4'd7;
    localparam logic [3:0] S_DIV_I    = 4'd8;
    localparam logic [3:0] S_RES_RD   = 4'd9;
    localparam logic [3:0] S_RES_MUL  = 4'd10;
    localparam logic [3:0] S_RES_CMP  = 4'd11;
    localparam logic [3:0] S_EMIT     = 4'd12;

    logic [3:0] r_state, n_state;
    t_mul_op    r_op, n_op;

    assign o_in_ready = (r_state == S_LOAD);

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        o_cmd.fit_init = 1'b1;
                        n_state        = S_ACC_INIT;
                    end
                end
            end
            S_ACC_INIT: begin
                o_cmd.acc_init = 1'b1;
                n_state        = S_ACC_RD;
            end
            S_ACC_RD: begin
                if (i_stat.idx_end) begin
                    n_op    = OpDenA;
                    n_state = S_MUL_GO;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_ACC_ADD;
                end
            end
            S_ACC_ADD: begin
                o_cmd.acc     = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state       = S_ACC_RD;
            end
            S_MUL_GO: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_op    = r_op;
                n_state         = S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
                if (i_stat.mul_done) begin
                    if (r_op == OpNiB) begin
                        n_state = S_CHECK;
                    end else begin
                        n_op    = t_mul_op'(r_op + 3'd1);
                        n_state = S_MUL_GO;
                    end
                end
            end
            S_CHECK: begin
                if (i_stat.fit_bad) begin
                    o_cmd.set_degen = 1'b1;
                    n_state         = S_EMIT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DivGrad;
                    n_state         = S_DIV_G;
                end
            end
            S_DIV_G: begin
                if (i_stat.div_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DivIcpt;
                    n_state         = S_DIV_I;
                end
            end
            S_DIV_I: begin
                if (i_stat.div_done) begin
                    if (i_stat.pass_max) begin
                        n_state = S_EMIT;
                    end else begin
                        o_cmd.res_init = 1'b1;
                        n_state        = S_RES_RD;
                    end
                end
            end
            S_RES_RD: begin
                if (i_stat.idx_end) begin
                    n_state = i_stat.any_rej ? S_ACC_INIT : S_EMIT;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_RES_MUL;
                end
            end
            S_RES_MUL: begin
                o_cmd.res_mul = 1'b1;
                n_state       = S_RES_CMP;
            end
            S_RES_CMP: begin
                o_cmd.res_cmp = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state       = S_RES_RD;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_op    <= OpDenA;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

endmodule

FILE: hw/rtl/lfor_datapath.sv
// Datapath of the line fit unit: point store, sums, serial multiplier,
// restoring divider, residual test and output register. Depends on lfor_pkg.
module lfor_datapath
    import lfor_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctl_cmd                i_cmd,
    output t_ctl_stat               o_stat,
    input  logic [OffW-1:0]         i_offset_km,
    input  logic signed [TimeW-1:0] i_travel_time,
    input  logic                    i_usable,
    input  logic                    i_cfg_wr_en,
    input  logic [LimW-1:0]         i_cfg_wr_data,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [OutW-1:0]         o_intercept,
    output logic [OutW-1:0]         o_gradient,
    output logic [CntW-1:0]         o_used_count,
    output logic [CntW-1:0]         o_rejected_count,
    output logic [PassW-1:0]        o_pass_count,
    output logic                    o_degenerate,
    output logic                    o_dropped
);

    // point store
    logic [OffW+TimeW-1:0] mem_pt  [MaxPoints];
    logic                  mem_vld [MaxPoints];
    logic [OffW+TimeW-1:0] r_rd_pt;
    logic                  r_rd_vld;

    logic [LimW-1:0]  r_limit;
    logic [CntW-1:0]  r_loaded;
    logic             r_overflow;
    logic [CntW-1:0]  r_idx;
    logic             room;
    logic             pt_we;
    logic             vld_we;
    logic [AddrW-1:0] vld_addr;
    logic             vld_data;

    // sums
    logic [27:0]        r_sx;
    logic [43:0]        r_sxx;
    logic signed [35:0] r_sy;
    logic signed [52:0] r_sxy;
    logic [CntW-1:0]    r_used;
    logic [OffW-1:0]    pt_x;
    logic signed [TimeW-1:0] pt_y;
    logic [31:0]        xx;
    logic signed [40:0] xy;

    // fit results
    logic signed [AccW-1:0] r_den, r_ns, r_ni;
    logic signed [OutW-1:0] r_grad, r_icpt;
    logic [PassW-1:0]       r_passes;
    logic [CntW-1:0]        r_rejected;
    logic                   r_degen;
    logic                   r_any;

    // serial multiplier
    logic signed [AccW-1:0]  mul_a;
    logic signed [MulBW-1:0] mul_b;
    logic signed [AccW-1:0]  r_ma, r_macc;
    logic [MulBW-1:0]        r_mb;
    logic [MulCntW-1:0]      r_mcnt;
    logic                    r_mbusy, r_mdone;
    t_mul_op                 r_mop;

    // restoring divider
    logic signed [AccW-1:0] div_num;
    logic [AccW-1:0]        r_dnum, r_dq;
    logic [DenW-1:0]        r_drem;
    logic [DenW-1:0]        den_mag;
    logic [DenW-1:0]        rem_sh;
    logic                   rem_ge;
    logic [DivCntW-1:0]     r_dcnt;
    logic                   r_dbusy, r_dfin, r_dneg, r_dsel;
    logic                   rnd_up;
    logic [AccW:0]          q_rnd, q_lim, q_sat;
    logic [OutW-1:0]        div_res;

    // residual test
    logic signed [48:0] r_rprod;
    logic signed [32:0] r_rdiff;
    logic signed [53:0] res_val;
    logic [53:0]        res_abs;
    logic [53:0]        res_lim;
    logic               reject;

    // output register
    logic                   r_out_valid;
    logic [OutW-1:0]        r_o_icpt, r_o_grad;
    logic [CntW-1:0]        r_o_used, r_o_rej;
    logic [PassW-1:0]       r_o_pass;
    logic                   r_o_degen, r_o_drop;

    assign room   = (r_loaded < CntW'(MaxPoints));
    assign pt_we  = i_cmd.load && room;
    assign pt_x   = r_rd_pt[OffW-1:0];
    assign pt_y   = $signed(r_rd_pt[OffW+TimeW-1:OffW]);
    assign xx     = pt_x * pt_x;
    assign xy     = $signed({1'b0, pt_x}) * pt_y;

    assign res_val = $signed({r_rdiff, 20'd0}) - $signed({{5{r_rprod[48]}}, r_rprod});
    assign res_abs = res_val[53] ? 54'(-res_val) : 54'(res_val);
    assign res_lim = {18'd0, r_limit, 20'd0};
    assign reject  = r_rd_vld && (res_abs > res_lim);

    assign vld_we   = pt_we || (i_cmd.res_cmp && reject);
    assign vld_addr = i_cmd.load ? r_loaded[AddrW-1:0] : r_idx[AddrW-1:0];
    assign vld_data = i_cmd.load ? i_usable : 1'b0;

    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            mem_pt[r_loaded[AddrW-1:0]] <= {i_travel_time, i_offset_km};
        end
        if (i_cmd.rd) begin
            r_rd_pt <= mem_pt[r_idx[AddrW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (vld_we) begin
            mem_vld[vld_addr] <= vld_data;
        end
        if (i_cmd.rd) begin
            r_rd_vld <= mem_vld[r_idx[AddrW-1:0]];
        end
    end

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_op)
            OpDenA: begin
                mul_a = $signed({{(AccW-44){1'b0}}, r_sxx});
                mul_b = $signed({{(MulBW-CntW){1'b0}}, r_used});
            end
            OpDenB: begin
                mul_a = $signed({{(AccW-28){1'b0}}, r_sx});
                mul_b = $signed({{(MulBW-28){1'b0}}, r_sx});
            end
            OpNsA: begin
                mul_a = {{(AccW-53){r_sxy[52]}}, r_sxy};
                mul_b = $signed({{(MulBW-CntW){1'b0}}, r_used});
            end
            OpNsB: begin
                mul_a = {{(AccW-36){r_sy[35]}}, r_sy};
                mul_b = $signed({{(MulBW-28){1'b0}}, r_sx});
            end
            OpNiA: begin
                mul_a = {{(AccW-36){r_sy[35]}}, r_sy};
                mul_b = $signed({{(MulBW-44){1'b0}}, r_sxx});
            end
            OpNiB: begin
                mul_a = {{(AccW-53){r_sxy[52]}}, r_sxy};
                mul_b = $signed({{(MulBW-28){1'b0}}, r_sx});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider helpers
    assign div_num = (i_cmd.div_sel == DivGrad) ? (r_ns <<< GradShift) : r_ni;
    assign den_mag = r_den[DenW-1:0];
    assign rem_sh  = {r_drem[DenW-2:0], r_dnum[AccW-1]};
    assign rem_ge  = (rem_sh >= den_mag);
    assign rnd_up  = ({r_drem, 1'b0} >= {1'b0, den_mag});
    assign q_rnd   = {1'b0, r_dq} + (AccW+1)'(rnd_up);
    assign q_lim   = r_dneg ? (AccW+1)'(33'h0_8000_0000) : (AccW+1)'(33'h0_7FFF_FFFF);
    assign q_sat   = (q_rnd > q_lim) ? q_lim : q_rnd;
    assign div_res = r_dneg ? (OutW'(0) - q_sat[OutW-1:0]) : q_sat[OutW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LimitReset;
            r_loaded    <= '0;
            r_overflow  <= 1'b0;
            r_mbusy     <= 1'b0;
            r_mdone     <= 1'b0;
            r_dbusy     <= 1'b0;
            r_dfin      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            // load or drop the incoming point
            if (i_cmd.load) begin
                if (room) begin
                    r_loaded <= r_loaded + CntW'(1);
                end else begin
                    r_overflow <= 1'b1;
                end
            end
            // multiplier control
            r_mdone <= 1'b0;
            if (i_cmd.mul_start) begin
                r_mbusy <= 1'b1;
            end else if (r_mbusy && r_mcnt == MulCntW'(MulSteps - 1)) begin
                r_mbusy <= 1'b0;
                r_mdone <= 1'b1;
            end
            // divider control
            r_dfin <= 1'b0;
            if (i_cmd.div_start) begin
                r_dbusy <= 1'b1;
            end else if (r_dbusy && r_dcnt == DivCntW'(DivSteps - 1)) begin
                r_dbusy <= 1'b0;
                r_dfin  <= 1'b1;
            end
            // output register
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_loaded    <= '0;
                r_overflow  <= 1'b0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // point loop index and sums
        if (i_cmd.acc_init || i_cmd.res_init) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + CntW'(1);
        end
        if (i_cmd.acc_init) begin
            r_sx     <= '0;
            r_sxx    <= '0;
            r_sy     <= '0;
            r_sxy    <= '0;
            r_used   <= '0;
            r_passes <= r_passes + PassW'(1);
        end else if (i_cmd.acc && r_rd_vld) begin
            r_sx   <= r_sx + 28'(pt_x);
            r_sxx  <= r_sxx + 44'(xx);
            r_sy   <= r_sy + 36'(pt_y);
            r_sxy  <= r_sxy + {{12{xy[40]}}, xy};
            r_used <= r_used + CntW'(1);
        end
        if (i_cmd.fit_init) begin
            r_passes   <= '0;
            r_rejected <= '0;
            r_degen    <= 1'b0;
        end

        // shift-add multiplier, sign folded into the addend
        if (i_cmd.mul_start) begin
            r_ma   <= mul_b[MulBW-1] ? -mul_a : mul_a;
            r_mb   <= mul_b[MulBW-1] ? MulBW'(-mul_b) : MulBW'(mul_b);
            r_macc <= '0;
            r_mcnt <= '0;
            r_mop  <= i_cmd.mul_op;
        end else if (r_mbusy) begin
            if (r_mb[0]) begin
                r_macc <= r_macc + r_ma;
            end
            r_ma   <= r_ma <<< 1;
            r_mb   <= r_mb >> 1;
            r_mcnt <= r_mcnt + MulCntW'(1);
        end
        if (r_mdone) begin
            case (r_mop)
                OpDenA:  r_den <= r_macc;
                OpDenB:  r_den <= r_den - r_macc;
                OpNsA:   r_ns  <= r_macc;
                OpNsB:   r_ns  <= r_ns - r_macc;
                OpNiA:   r_ni  <= r_macc;
                OpNiB:   r_ni  <= r_ni - r_macc;
                default: r_den <= r_den;
            endcase
        end

        // restoring divider, one quotient bit per cycle
        if (i_cmd.div_start) begin
            r_dnum <= div_num[AccW-1] ? AccW'(-div_num) : AccW'(div_num);
            r_dneg <= div_num[AccW-1];
            r_dsel <= i_cmd.div_sel;
            r_drem <= '0;
            r_dq   <= '0;
            r_dcnt <= '0;
        end else if (r_dbusy) begin
            r_drem <= rem_ge ? (rem_sh - den_mag) : rem_sh;
            r_dq   <= {r_dq[AccW-2:0], rem_ge};
            r_dnum <= r_dnum << 1;
            r_dcnt <= r_dcnt + DivCntW'(1);
        end
        if (r_dfin) begin
            if (r_dsel == DivGrad) begin
                r_grad <= div_res;
            end else begin
                r_icpt <= div_res;
            end
        end
        if (i_cmd.set_degen) begin
            r_degen <= 1'b1;
            r_grad  <= '0;
            r_icpt  <= '0;
        end

        // residual test
        if (i_cmd.res_init) begin
            r_any <= 1'b0;
        end
        if (i_cmd.res_mul) begin
            r_rprod <= r_grad * $signed({1'b0, pt_x});
            r_rdiff <= {{9{pt_y[TimeW-1]}}, pt_y} - {r_icpt[OutW-1], r_icpt};
        end
        if (i_cmd.res_cmp && reject) begin
            r_rejected <= r_rejected + CntW'(1);
            r_any      <= 1'b1;
        end

        if (i_cmd.emit) begin
            r_o_icpt  <= r_icpt;
            r_o_grad  <= r_grad;
            r_o_used  <= r_used;
            r_o_rej   <= r_rejected;
            r_o_pass  <= r_passes;
            r_o_degen <= r_degen;
            r_o_drop  <= r_overflow;
        end
    end

    assign o_stat.idx_end  = (r_idx == r_loaded);
    assign o_stat.mul_done = r_mdone;
    assign o_stat.div_done = r_dfin;
    assign o_stat.fit_bad  = (r_used < CntW'(2)) || (r_den == '0);
    assign o_stat.pass_max = (r_passes >= PassW'(MaxPasses));
    assign o_stat.any_rej  = r_any;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_intercept      = r_o_icpt;
    assign o_gradient       = r_o_grad;
    assign o_used_count     = r_o_used;
    assign o_rejected_count = r_o_rej;
    assign o_pass_count     = r_o_pass;
    assign o_degenerate     = r_o_degen;
    assign o_dropped        = r_o_drop;

endmodule

FILE: hw/rtl/line_fit_outlier_reject_unit.sv
// Top level of the line fit unit with outlier rejection.
// Depends on lfor_pkg, lfor_ctrl and lfor_datapath.
//
//  channel   | dir | handshake             | payload
//  ----------+-----+-----------------------+-----------------------------------------
//  s_axis    | in  | tvalid/tready         | tdata: offset, time; tuser: usable; tlast
//  m_axis    | out | tvalid/tready         | tdata: fit and counts; tuser: flags
//  cfg       | in  | i_cfg_wr_en           | i_cfg_wr_data: residual limit
//
// Points load while the unit is idle. The last point starts the fit; each pass
// accumulates over the N stored points, runs six products in the bit-serial multiplier
// and two quotients in the restoring divider, then tests residuals; up to 16 passes.
// Input stalls during the fit.
// Reset is synchronous, active low; the point store needs no clearing pass.
// A finished result waits in the output register while new points load.
module line_fit_outlier_reject_unit
    import lfor_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // points in
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [39:0]       s_axis_tdata,   // [15:0] offset_km, [39:16] travel_time
    input  logic              s_axis_tuser,   // [0] usable
    input  logic              s_axis_tlast,   // last_point
    // fit result out
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [95:0]       m_axis_tdata,   // [31:0] intercept, [63:32] gradient,
                                              // [76:64] used_count, [89:77] rejected_count,
                                              // [94:90] pass_count, [95] zero
    output logic [1:0]        m_axis_tuser,   // [0] degenerate, [1] dropped
    // residual limit register
    input  logic              i_cfg_wr_en,
    input  logic [LimW-1:0]   i_cfg_wr_data
);

    t_ctl_cmd         cmd;
    t_ctl_stat        stat;
    logic [OutW-1:0]  intercept;
    logic [OutW-1:0]  gradient;
    logic [CntW-1:0]  used_count;
    logic [CntW-1:0]  rejected_count;
    logic [PassW-1:0] pass_count;
    logic             degenerate;
    logic             dropped;

    // Sequence the load, accumulate, solve and rejection passes.
    lfor_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // Hold the points, run the arithmetic and register the result.
    lfor_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_offset_km      (s_axis_tdata[OffW-1:0]),
        .i_travel_time    ($signed(s_axis_tdata[OffW+TimeW-1:OffW])),
        .i_usable         (s_axis_tuser),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_intercept      (intercept),
        .o_gradient       (gradient),
        .o_used_count     (used_count),
        .o_rejected_count (rejected_count),
        .o_pass_count     (pass_count),
        .o_degenerate     (degenerate),
        .o_dropped        (dropped)
    );

    // Pack the result transaction, first field in the lowest bits.
    assign m_axis_tdata = {1'b0, pass_count, rejected_count, used_count, gradient, intercept};
    assign m_axis_tuser = {dropped, degenerate};

endmodule

FILE: hw/rtl/lfor_checker.sv
// Port-level checks of the line fit unit, bound to the top level.
// Depends on line_fit_outlier_reject_unit_defines.svh.
`include "line_fit_outlier_reject_unit_defines.svh"

module lfor_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a stalled result holds
    `LFOR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed under stall")

    // the last point stops intake while fitting
    `LFOR_ASSERT_NEXT(a_fit_stall, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "input accepted during fit")

    // degenerate fits report zero intercept and slope
    `LFOR_ASSERT_NOW(a_degen_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[63:0] == 64'd0, "degenerate fit with nonzero line")

    // at least one and at most sixteen passes
    `LFOR_ASSERT_NOW(a_pass_range, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tdata[94:90] >= 5'd1) && (m_axis_tdata[94:90] <= 5'd16), "pass count out of range")

endmodule

bind line_fit_outlier_reject_unit lfor_checker u_lfor_checker (.*);

FILE: tb/line_fit_outlier_reject_unit_test.sv
// Self-checking testbench for line_fit_outlier_reject_unit: streams point sets,
// predicts each fit result in a scoreboard class and compares every result field.
// Depends on lfor_pkg and the line_fit_outlier_reject_unit RTL.
`timescale 1ns / 1ps

// Holds the expected fit of each point set and checks the results against it.
class t_fit_scoreboard;
    typedef struct {
        longint intercept;
        longint gradient;
        int     used_count;
        int     rejected_count;
        int     pass_count;
        bit     degenerate;
        bit     dropped;
    } t_fit_result;

    bit [15:0]   pt_offset[lfor_pkg::MaxPoints];
    int          pt_time[lfor_pkg::MaxPoints];
    bit          pt_usable[lfor_pkg::MaxPoints];
    int          n_loaded;
    bit          overflow;
    int unsigned limit;
    t_fit_result fits_due[$];
    int          errors;

    function new();
        n_loaded = 0;
        overflow = 0;
        limit    = lfor_pkg::LimitReset;
        errors   = 0;
    endfunction

    function int pending();
        return fits_due.size();
    endfunction

    function void set_limit(int unsigned value);
        limit = value & 16'hFFFF;
    endfunction

    // round(num/den), ties away from zero, saturated to 32 bits; den > 0
    function longint round_div(logic signed [127:0] num, logic signed [127:0] den);
        logic [127:0] mag, q, rm, d;
        bit neg;
        neg = num < 0;
        mag = neg ? -num : num;
        d   = den;
        q   = mag / d;
        rm  = mag % d;
        if ((rm << 1) >= d) q = q + 1;
        if (neg && q > 128'h8000_0000) q = 128'h8000_0000;
        if (!neg && q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function void fit_set();
        t_fit_result res;
        logic signed [127:0] w_used, w_sx, w_sxx, w_sy, w_sxy, den, ns, ni, r, rlim;
        longint sx, sxx, sy, sxy;
        int used;
        bit any;
        res = '{default: 0};
        forever begin
            sx = 0; sxx = 0; sy = 0; sxy = 0; used = 0; any = 0;
            for (int i = 0; i < n_loaded; i++) begin
                if (pt_usable[i]) begin
                    sx  += longint'(pt_offset[i]);
                    sxx += longint'(pt_offset[i]) * longint'(pt_offset[i]);
                    sy  += pt_time[i];
                    sxy += longint'(pt_offset[i]) * pt_time[i];
                    used++;
                end
            end
            res.pass_count++;
            res.used_count = used;
            w_used = used; w_sx = sx; w_sxx = sxx; w_sy = sy; w_sxy = sxy;
            den = w_used * w_sxx - w_sx * w_sx;
            if (used < 2 || den == 0) begin
                res.degenerate = 1;
                res.intercept  = 0;
                res.gradient   = 0;
                break;
            end
            ns = (w_used * w_sxy - w_sx * w_sy) <<< lfor_pkg::GradShift;
            ni = w_sy * w_sxx - w_sx * w_sxy;
            res.gradient  = round_div(ns, den);
            res.intercept = round_div(ni, den);
            if (res.pass_count >= lfor_pkg::MaxPasses) break;
            // residual in units of 2^-20 of the travel time LSB, against the limit scaled the same way
            rlim = 128'(limit) <<< 20;
            for (int i = 0; i < n_loaded; i++) begin
                if (pt_usable[i]) begin
                    r = ((128'(signed'(pt_time[i])) - 128'(signed'(res.intercept))) <<< 20)
                        - 128'(signed'(res.gradient)) * 128'(pt_offset[i]);
                    if (r < 0) r = -r;
                    if (r > rlim) begin
                        pt_usable[i] = 0;
                        res.rejected_count++;
                        any = 1;
                    end
                end
            end
            if (!any) break;
        end
        res.dropped = overflow;
        fits_due.push_back(res);
        n_loaded = 0;
        overflow = 0;
    endfunction

    // note one accepted point transaction; the last point closes the set
    function void note_point(bit [15:0] off, bit [23:0] tm, bit usable, bit last);
        if (n_loaded < lfor_pkg::MaxPoints) begin
            pt_offset[n_loaded] = off;
            pt_time[n_loaded]   = int'(signed'(tm));
            pt_usable[n_loaded] = usable;
            n_loaded++;
        end else begin
            overflow = 1;
        end
        if (last) fit_set();
    endfunction

    task report(string field, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", field, got, want);
        errors++;
    endtask

    task check_result(logic [95:0] data, logic [1:0] flags);
        t_fit_result e;
        if (fits_due.size() == 0) begin
            report("unexpected result", 1, 0);
            return;
        end
        e = fits_due.pop_front();
        if (longint'(signed'(data[31:0])) != e.intercept)
            report("intercept", longint'(signed'(data[31:0])), e.intercept);
        if (longint'(signed'(data[63:32])) != e.gradient)
            report("gradient", longint'(signed'(data[63:32])), e.gradient);
        if (data[76:64] != e.used_count) report("used_count", data[76:64], e.used_count);
        if (data[89:77] != e.rejected_count)
            report("rejected_count", data[89:77], e.rejected_count);
        if (data[94:90] != e.pass_count) report("pass_count", data[94:90], e.pass_count);
        if (data[95] !== 1'b0) report("pad bit", data[95], 0);
        if (flags[0] != e.degenerate) report("degenerate", flags[0], e.degenerate);
        if (flags[1] != e.dropped) report("dropped", flags[1], e.dropped);
    endtask
endclass

module line_fit_outlier_reject_unit_test;
    import lfor_pkg::*;

    localparam int IdleLimit  = 2000000;   // a full store refit 16 times fits well inside
    localparam int RandPoints = 1800;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              s_axis_tvalid = 0;
    logic              s_axis_tready;
    logic [39:0]       s_axis_tdata = '0;  // [15:0] offset_km, [39:16] travel_time
    logic              s_axis_tuser = 0;   // [0] usable
    logic              s_axis_tlast = 0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 0;
    logic [95:0]       m_axis_tdata;       // [31:0] intercept, [63:32] gradient,
                                           // [76:64] used, [89:77] rejected, [94:90] passes
    logic [1:0]        m_axis_tuser;       // [0] degenerate, [1] dropped
    logic              i_cfg_wr_en = 0;
    logic [LimW-1:0]   i_cfg_wr_data = '0;

    t_fit_scoreboard fits = new();
    bit  tx_calm, rx_calm;  // phases with no idling on either side
    int  idle_cycles;
    int  sent;

    line_fit_outlier_reject_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // Check every result transaction at the edge that accepts it.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) fits.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IdleLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result sink: unless rx_calm is set, stall a random number of cycles before each transaction.
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!rx_calm) begin
                m_axis_tready = 0;
                repeat ($urandom_range(0, 5)) @(negedge i_clk);
            end
            m_axis_tready = 1;
            forever begin
                @(posedge i_clk);
                if (m_axis_tvalid) break;
            end
        end
    end

    // Drive one point; called at a falling edge, returns at a falling edge with tvalid held.
    task automatic send_point(input bit [15:0] off, input bit [23:0] tm, input bit usable,
                              input bit last);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid = 0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {tm, off};
        s_axis_tuser  = usable;
        s_axis_tlast  = last;
        s_axis_tvalid = 1;
        forever begin
            @(posedge i_clk);
            if (s_axis_tready) break;
        end
        fits.note_point(off, tm, usable, last);
        sent++;
        @(negedge i_clk);
    endtask

    // Hold until every expected fit is out, then let the block settle.
    task automatic drain();
        s_axis_tvalid = 0;
        while (fits.pending() > 0) @(posedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_limit(input bit [15:0] value);
        i_cfg_wr_en   = 1;
        i_cfg_wr_data = value;
        @(negedge i_clk);
        i_cfg_wr_en   = 0;
        fits.set_limit(value);
    endtask

    // A set of points near a random line, with noise, outliers and some unusable points.
    task automatic send_line_set(input int n);
        int a, sl, x, y, xmax, pick;
        pick = $urandom_range(0, 2);
        xmax = pick == 0 ? 255 : (pick == 1 ? 4095 : 65535);
        a  = int'($urandom_range(0, 2000000)) - 1000000;
        sl = int'($urandom_range(0, 256)) - 128;
        for (int i = 0; i < n; i++) begin
            x = $urandom_range(0, xmax);
            y = a + (x * sl) / 16 + int'($urandom_range(0, 600)) - 300;
            if ($urandom_range(0, 7) == 0)
                y += ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(3000, 200000));
            if (y > 8388607) y = 8388607;
            if (y < -8388608) y = -8388608;
            send_point(x, y, $urandom_range(0, 9) != 0, i == n - 1);
        end
    endtask

    initial begin
        tx_calm = 0;
        rx_calm = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: lone point, coincident offsets, field extremes, no usable points
        send_point(16'd100, 24'd5000, 1, 1);
        send_point(16'd7, 24'd10, 1, 0);
        send_point(16'd7, 24'd900, 1, 1);
        send_point(16'd0, 24'h800000, 1, 0);
        send_point(16'hFFFF, 24'h7FFFFF, 1, 0);
        send_point(16'hFFFF, 24'h800000, 1, 0);
        send_point(16'd0, 24'h7FFFFF, 1, 0);
        send_point(16'h8000, 24'd0, 0, 1);
        send_point(16'd3, 24'd30, 0, 0);
        send_point(16'd9, 24'd90, 0, 1);
        send_point(16'd0, 24'd0, 1, 0);
        send_point(16'd16, 24'd256, 1, 0);
        send_point(16'd32, 24'd512, 1, 0);
        send_point(16'd48, 24'd60000, 1, 1);   // one far outlier on a clean line
        drain();

        // limit at its extremes on a short noisy set
        write_limit(16'd0);
        send_line_set(12);
        drain();
        write_limit(16'hFFFF);
        send_line_set(12);
        drain();

        // random phases, each with its own limit and idling pattern
        while (sent < RandPoints) begin
            tx_calm = $urandom_range(0, 3) == 0;
            rx_calm = $urandom_range(0, 3) == 0;
            case ($urandom_range(0, 3))
                0:       write_limit($urandom_range(0, 65535));
                1:       write_limit(16'd0);
                default: write_limit($urandom_range(16, 4000));
            endcase
            for (int k = 0; k < 240; ) begin
                int n;
                if ($urandom_range(0, 9) == 0) begin
                    // raw point with every field random
                    send_point($urandom, $urandom, $urandom, $urandom_range(0, 3) == 0);
                    k++;
                end else begin
                    n = $urandom_range(0, 19) == 0 ? $urandom_range(60, 200)
                                                   : $urandom_range(1, 24);
                    send_line_set(n);
                    k += n;
                end
            end
            send_point($urandom, $urandom, $urandom, 1);   // close any open set
            drain();
        end

        repeat (100) @(negedge i_clk);
        if (fits.errors == 0 && fits.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
